/* rtl/cbcp_pkg.sv */
`timescale 1ns / 1ps

package cbcp_pkg;

    localparam int DEF_MAX_SAMPLES     = 1024;
    localparam int DEF_COORD_WIDTH     = 21;
    localparam int DEF_PARAM_FRAC_BITS = 16;

    localparam int QUERY_WIDTH  = 21;
    localparam int COUNT_WIDTH  = 11;
    localparam int CFG_WIDTH    = 63;
    localparam int CFG_IDX_W    = 2;
    localparam int RESULT_WIDTH = 17;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_START_POINT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HANDLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HANDLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_POINT     = 2'd3;

    // Number of interpolations issued in each level, and squares per sample.
    localparam int LEVEL1_OPS = 9;
    localparam int LEVEL2_OPS = 6;
    localparam int LEVEL3_OPS = 3;
    localparam int SQUARE_OPS = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_L1,
        ST_D1,
        ST_C1,
        ST_L2,
        ST_D2,
        ST_C2,
        ST_L3,
        ST_D3,
        ST_C3,
        ST_SQ,
        ST_DQ,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        COPY_OFF0,
        COPY_OFF3,
        COPY_OFF6
    } copy_off_t;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      div_first;
        logic      pts_load;
        logic      copy;
        copy_off_t copy_off;
        logic      issue;
        logic      square;
        logic      compare;
        logic      advance;
    } cmd_t;

    typedef struct packed {
        logic last_sample;
    } status_t;

endpackage

/* rtl/cbcp_ctrl.sv */
`timescale 1ns / 1ps

module cbcp_ctrl #(
    parameter int PARAM_FRAC_BITS = cbcp_pkg::DEF_PARAM_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cbcp_pkg::status_t status,
    output cbcp_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    localparam int CNTW = $clog2(PARAM_FRAC_BITS + 2);

    cbcp_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             div_last, l1_last, l2_last, l3_last, sq_last;

    assign div_last = (cnt_reg == CNTW'(PARAM_FRAC_BITS));
    assign l1_last  = (cnt_reg == CNTW'(cbcp_pkg::LEVEL1_OPS - 1));
    assign l2_last  = (cnt_reg == CNTW'(cbcp_pkg::LEVEL2_OPS - 1));
    assign l3_last  = (cnt_reg == CNTW'(cbcp_pkg::LEVEL3_OPS - 1));
    assign sq_last  = (cnt_reg == CNTW'(cbcp_pkg::SQUARE_OPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbcp_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            cbcp_pkg::ST_IDLE: if (start) state_next = cbcp_pkg::ST_DIV;
            cbcp_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = cbcp_pkg::ST_L1;
                    cnt_next   = '0;
                end
            end
            cbcp_pkg::ST_L1:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (l1_last)
                begin
                    state_next = cbcp_pkg::ST_D1;
                    cnt_next   = '0;
                end
            end
            cbcp_pkg::ST_D1: state_next = cbcp_pkg::ST_C1;
            cbcp_pkg::ST_C1: state_next = cbcp_pkg::ST_L2;
            cbcp_pkg::ST_L2:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (l2_last)
                begin
                    state_next = cbcp_pkg::ST_D2;
                    cnt_next   = '0;
                end
            end
            cbcp_pkg::ST_D2: state_next = cbcp_pkg::ST_C2;
            cbcp_pkg::ST_C2: state_next = cbcp_pkg::ST_L3;
            cbcp_pkg::ST_L3:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (l3_last)
                begin
                    state_next = cbcp_pkg::ST_D3;
                    cnt_next   = '0;
                end
            end
            cbcp_pkg::ST_D3: state_next = cbcp_pkg::ST_C3;
            cbcp_pkg::ST_C3: state_next = cbcp_pkg::ST_SQ;
            cbcp_pkg::ST_SQ:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (sq_last)
                begin
                    state_next = cbcp_pkg::ST_DQ;
                    cnt_next   = '0;
                end
            end
            cbcp_pkg::ST_DQ: state_next = cbcp_pkg::ST_CMP;
            cbcp_pkg::ST_CMP:
                state_next = status.last_sample ? cbcp_pkg::ST_DONE : cbcp_pkg::ST_L1;
            cbcp_pkg::ST_DONE: state_next = cbcp_pkg::ST_IDLE;
            default: state_next = cbcp_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd          = '0;
        cmd.copy_off = cbcp_pkg::COPY_OFF0;
        busy         = 1'b1;
        done         = 1'b0;
        unique case (state_reg)
            cbcp_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            cbcp_pkg::ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cmd.pts_load  = div_last;
            end
            cbcp_pkg::ST_L1, cbcp_pkg::ST_L2, cbcp_pkg::ST_L3: cmd.issue = 1'b1;
            cbcp_pkg::ST_C1: cmd.copy = 1'b1;
            cbcp_pkg::ST_C2:
            begin
                cmd.copy     = 1'b1;
                cmd.copy_off = cbcp_pkg::COPY_OFF3;
            end
            cbcp_pkg::ST_C3:
            begin
                cmd.copy     = 1'b1;
                cmd.copy_off = cbcp_pkg::COPY_OFF6;
            end
            cbcp_pkg::ST_SQ:
            begin
                cmd.issue  = 1'b1;
                cmd.square = 1'b1;
            end
            cbcp_pkg::ST_CMP:
            begin
                cmd.compare  = 1'b1;
                cmd.advance  = !status.last_sample;
                cmd.pts_load = !status.last_sample;
            end
            cbcp_pkg::ST_DONE: done = 1'b1;
            cbcp_pkg::ST_D1, cbcp_pkg::ST_D2, cbcp_pkg::ST_D3, cbcp_pkg::ST_DQ: ;
            default: busy = 1'b1;
        endcase
    end

`ifndef SYNTH
    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_done_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.compare))
        else $error("result given without a final compare");
`endif

endmodule

/* rtl/cbcp_datapath.sv */
`timescale 1ns / 1ps

module cbcp_datapath #(
    parameter int MAX_SAMPLES     = cbcp_pkg::DEF_MAX_SAMPLES,
    parameter int COORD_WIDTH     = cbcp_pkg::DEF_COORD_WIDTH,
    parameter int PARAM_FRAC_BITS = cbcp_pkg::DEF_PARAM_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cbcp_pkg::cmd_t                      cmd,
    output cbcp_pkg::status_t                   status,
    input  logic                                cfg_we,
    input  logic [cbcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbcp_pkg::CFG_WIDTH-1:0]      cfg_data,
    input  logic signed [COORD_WIDTH-1:0]       query_x,
    input  logic signed [COORD_WIDTH-1:0]       query_y,
    input  logic signed [COORD_WIDTH-1:0]       query_z,
    input  logic [cbcp_pkg::COUNT_WIDTH-1:0]    sample_count,
    output logic [PARAM_FRAC_BITS:0]           nearest_param
);

    localparam int C   = COORD_WIDTH;
    localparam int F   = PARAM_FRAC_BITS;
    localparam int PTW = 3 * C;
    localparam int NW  = $clog2(MAX_SAMPLES + 1);
    localparam int TW  = F + 1;
    localparam int MBW = (F + 2 > C + 1) ? F + 2 : C + 1;
    localparam int PW  = C + 1 + MBW;
    localparam int DW  = 2 * C + 2;
    localparam int CW  = (cbcp_pkg::COUNT_WIDTH > NW) ? cbcp_pkg::COUNT_WIDTH : NW;

    logic [PTW-1:0] pt_reg [4];

    logic [NW-1:0] n_reg, rem_reg, racc_reg;
    logic [TW-1:0] quo_reg, t_reg, best_t_reg;
    logic [NW-1:0] i_reg;
    logic [DW-1:0] dist_reg, best_d_reg;
    logic          first_reg;

    logic signed [C-1:0] q_reg [3];
    logic signed [C-1:0] ql_reg [3];
    logic signed [C-1:0] w_reg [12];
    logic signed [C-1:0] r_reg [9];

    logic signed [PW-1:0] prod_reg;
    logic signed [C-1:0]  base_reg;
    logic                 wb_reg, wb_sq_reg;

    // Configuration registers; bits above the three coordinates are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 4; j++) pt_reg[j] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbcp_pkg::REG_START_POINT:   pt_reg[0] <= cfg_data[PTW-1:0];
                cbcp_pkg::REG_FIRST_HANDLE:  pt_reg[1] <= cfg_data[PTW-1:0];
                cbcp_pkg::REG_SECOND_HANDLE: pt_reg[2] <= cfg_data[PTW-1:0];
                cbcp_pkg::REG_END_POINT:     pt_reg[3] <= cfg_data[PTW-1:0];
                default: ;
            endcase
        end
    end

    // Interval count, clamped to one and to the sample limit.
    logic [CW-1:0] cnt_ext;
    logic [NW-1:0] n_clamp;
    always_comb
    begin
        cnt_ext = CW'(sample_count);
        if (cnt_ext == '0)
            n_clamp = NW'(1);
        else if (cnt_ext > CW'(MAX_SAMPLES))
            n_clamp = NW'(MAX_SAMPLES);
        else
            n_clamp = cnt_ext[NW-1:0];
    end

    // One restoring step of 2^F / n: quotient and remainder of the t step.
    logic [NW:0] rem_sh, rem_sub;
    logic        qbit;
    assign rem_sh  = {rem_reg, cmd.div_first};
    assign qbit    = (rem_sh >= {1'b0, n_reg});
    assign rem_sub = rem_sh - {1'b0, n_reg};

    // t steps by quotient plus remainder, with one carry from the remainder.
    logic [NW:0] racc_sum;
    logic        racc_ge;
    assign racc_sum = {1'b0, racc_reg} + {1'b0, rem_reg};
    assign racc_ge  = (racc_sum >= {1'b0, n_reg});

    // Shared multiplier: (b - a) * t for interpolation, diff * diff for distance.
    logic signed [C:0]     diff;
    logic signed [MBW-1:0] mb;
    logic signed [PW-1:0]  prod_next;
    always_comb
    begin
        if (cmd.square)
        begin
            diff = $signed({w_reg[0][C-1], w_reg[0]}) - $signed({ql_reg[0][C-1], ql_reg[0]});
            mb   = MBW'(diff);
        end
        else
        begin
            diff = $signed({w_reg[3][C-1], w_reg[3]}) - $signed({w_reg[0][C-1], w_reg[0]});
            mb   = $signed({{(MBW - TW){1'b0}}, t_reg});
        end
        prod_next = diff * mb;
    end

    // Arithmetic shift floors toward minus infinity; result stays in range.
    logic signed [PW-1:0] lerp_sum;
    logic signed [C-1:0]  lerp_res;
    assign lerp_sum = PW'(base_reg) + (prod_reg >>> F);
    assign lerp_res = lerp_sum[C-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg    <= 1'b0;
            wb_sq_reg <= 1'b0;
            first_reg <= 1'b0;
            n_reg     <= NW'(1);
            racc_reg  <= '0;
            t_reg     <= '0;
        end
        else
        begin
            wb_reg    <= cmd.issue;
            wb_sq_reg <= cmd.square;
            if (cmd.load)
            begin
                n_reg     <= n_clamp;
                first_reg <= 1'b1;
                racc_reg  <= '0;
                t_reg     <= '0;
            end
            if (cmd.compare)
                first_reg <= 1'b0;
            if (cmd.advance)
            begin
                racc_reg <= racc_ge ? racc_sum[NW-1:0] - n_reg : racc_sum[NW-1:0];
                t_reg    <= t_reg + quo_reg + TW'(racc_ge);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            i_reg    <= '0;
            q_reg[0] <= query_x;
            q_reg[1] <= query_y;
            q_reg[2] <= query_z;
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
            quo_reg <= {quo_reg[TW-2:0], qbit};
        end
        if (cmd.advance)
            i_reg <= i_reg + 1'b1;

        if (cmd.pts_load)
        begin
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < 3; k++)
                    w_reg[3 * j + k] <= pt_reg[j][k * C +: C];
        end
        else if (cmd.copy)
        begin
            unique case (cmd.copy_off)
                cbcp_pkg::COPY_OFF0: for (int j = 0; j < 9; j++) w_reg[j] <= r_reg[j];
                cbcp_pkg::COPY_OFF3: for (int j = 0; j < 6; j++) w_reg[j] <= r_reg[j + 3];
                cbcp_pkg::COPY_OFF6: for (int j = 0; j < 3; j++) w_reg[j] <= r_reg[j + 6];
                default: ;
            endcase
        end
        else if (cmd.issue)
        begin
            for (int j = 0; j < 11; j++) w_reg[j] <= w_reg[j + 1];
        end

        if (cmd.copy && cmd.copy_off == cbcp_pkg::COPY_OFF6)
        begin
            for (int k = 0; k < 3; k++) ql_reg[k] <= q_reg[k];
            dist_reg <= '0;
        end
        else if (cmd.square)
        begin
            ql_reg[0] <= ql_reg[1];
            ql_reg[1] <= ql_reg[2];
        end

        if (cmd.issue)
        begin
            prod_reg <= prod_next;
            base_reg <= w_reg[0];
        end

        if (wb_reg && !wb_sq_reg)
        begin
            for (int j = 0; j < 8; j++) r_reg[j] <= r_reg[j + 1];
            r_reg[8] <= lerp_res;
        end
        if (wb_reg && wb_sq_reg)
            dist_reg <= dist_reg + prod_reg[DW-1:0];

        if (cmd.compare && (first_reg || dist_reg < best_d_reg))
        begin
            best_d_reg <= dist_reg;
            best_t_reg <= t_reg;
        end
    end

    assign status.last_sample = (i_reg == n_reg);
    assign nearest_param      = best_t_reg;

`ifndef SYNTH
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        t_reg <= TW'(1 << F))
        else $error("sample parameter beyond one");
    a_racc_range: assert property (@(posedge clk) disable iff (!rst_n)
        racc_reg < n_reg)
        else $error("step remainder not below interval count");
    a_wb_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> wb_reg)
        else $error("issued operation lost its writeback");
`endif

endmodule

/* rtl/cubic_bezier_closest_parameter.sv */
`timescale 1ns / 1ps

// Nearest-sample search on a 3D cubic Bezier curve.
// Configuration: write cfg_data to register cfg_index (0 start point, 1 first
// handle, 2 second handle, 3 end point) with cfg_we; each holds x, y, z as
// packed signed Q12.8 values. Write only while busy is low.
// Request: query_x/y/z and sample_count are taken at a clock edge with start
// high and busy low. The block then samples t = floor(i*65536/N) for
// i = 0..N and reports the t of the nearest sample, earliest on a tie.
// Result: nearest_param is valid for the single cycle in which done is high.
// The receiver cannot stall; the result must be taken in that cycle.
// The block first computes the t step 2^F / n with a restoring divider,
// F being the fraction width of t. Then, per sample, the single shared
// multiplier issues 18 interpolations and three squares, one per cycle, and
// each of the four levels ends in a drain state and then a copy or compare
// state. A new request is taken in the cycle after done. Reset clears the
// control points to zero and returns the controller to idle.
module cubic_bezier_closest_parameter #(
    parameter int MAX_SAMPLES     = cbcp_pkg::DEF_MAX_SAMPLES,
    parameter int COORD_WIDTH     = cbcp_pkg::DEF_COORD_WIDTH,
    parameter int PARAM_FRAC_BITS = cbcp_pkg::DEF_PARAM_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [cbcp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [cbcp_pkg::CFG_WIDTH-1:0]          cfg_data,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [COORD_WIDTH-1:0]           query_x,
    input  logic signed [COORD_WIDTH-1:0]           query_y,
    input  logic signed [COORD_WIDTH-1:0]           query_z,
    input  logic [cbcp_pkg::COUNT_WIDTH-1:0]        sample_count,
    output logic                                    done,
    output logic [PARAM_FRAC_BITS:0]                nearest_param
);

    // Commands flow from the controller; the datapath reports the last sample.
    cbcp_pkg::cmd_t    cmd;
    cbcp_pkg::status_t status;

    cbcp_ctrl #(
        .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the control points, the step divider, the shared
    // multiplier and the running best distance.
    cbcp_datapath #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .COORD_WIDTH    (COORD_WIDTH),
        .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .query_x      (query_x),
        .query_y      (query_y),
        .query_z      (query_z),
        .sample_count (sample_count),
        .nearest_param(nearest_param)
    );

endmodule

/* dv/cubic_bezier_closest_parameter_test.sv */
`timescale 1ns / 1ps

// Scoreboard for the nearest-sample search. It keeps its own copy of the four
// control points, computes the expected parameter when a request is accepted
// and compares each reported parameter with the oldest expectation.
class nearest_param_board;
    logic [62:0]  ctrl_pts [4];
    logic [16:0]  pending [$];
    int           mismatches;
    int           checked;

    function new();
        foreach (ctrl_pts[k]) ctrl_pts[k] = '0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void write_point(logic [1:0] idx, logic [62:0] value);
        ctrl_pts[idx] = value;
    endfunction

    // a + floor((b - a) * t / 2^16); the arithmetic shift of a signed
    // value is already a floor toward minus infinity.
    function longint blend(longint a, longint b, longint t);
        longint prod;
        prod = (b - a) * t;
        return a + (prod >>> 16);
    endfunction

    function longint coord(int pt, int axis);
        logic signed [20:0] v;
        v = ctrl_pts[pt][axis*21 +: 21];
        return longint'(v);
    endfunction

    function void note_request(logic signed [20:0] qx, logic signed [20:0] qy,
                               logic signed [20:0] qz, logic [10:0] count);
        longint      query [3];
        longint      a, b, c, d, e, p, diff;
        longint unsigned n, t, sq_dist, best_dist, best_t;
        query[0] = qx;
        query[1] = qy;
        query[2] = qz;
        n = count;
        if (n == 0) n = 1;
        if (n > 1024) n = 1024;
        best_dist = 0;
        best_t = 0;
        for (longint unsigned i = 0; i <= n; i++)
        begin
            t = (i << 16) / n;
            sq_dist = 0;
            for (int axis = 0; axis < 3; axis++)
            begin
                a = blend(coord(0, axis), coord(1, axis), t);
                b = blend(coord(1, axis), coord(2, axis), t);
                c = blend(coord(2, axis), coord(3, axis), t);
                d = blend(a, b, t);
                e = blend(b, c, t);
                p = blend(d, e, t);
                diff = p - query[axis];
                sq_dist += longint'(diff * diff);
            end
            if (i == 0 || sq_dist < best_dist)
            begin
                best_dist = sq_dist;
                best_t = t;
            end
        end
        pending.push_back(best_t[16:0]);
    endfunction

    function void check_result(logic [16:0] actual);
        logic [16:0] wanted;
        if (pending.size() == 0)
        begin
            $error("nearest_param: unexpected result %0d", actual);
            mismatches++;
            return;
        end
        wanted = pending.pop_front();
        checked++;
        if (actual !== wanted)
        begin
            $error("nearest_param: expected %0d, actual %0d", wanted, actual);
            mismatches++;
        end
    endfunction
endclass

module cubic_bezier_closest_parameter_test;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    cfg_we;
    logic [cbcp_pkg::CFG_IDX_W-1:0]          cfg_index;
    logic [cbcp_pkg::CFG_WIDTH-1:0]          cfg_data;
    logic                                    start;
    logic                                    busy;
    logic signed [cbcp_pkg::QUERY_WIDTH-1:0] query_x;
    logic signed [cbcp_pkg::QUERY_WIDTH-1:0] query_y;
    logic signed [cbcp_pkg::QUERY_WIDTH-1:0] query_z;
    logic [cbcp_pkg::COUNT_WIDTH-1:0]        sample_count;
    logic                                    done;
    logic [cbcp_pkg::RESULT_WIDTH-1:0]       nearest_param;

    nearest_param_board board;
    longint unsigned    cycle_count;
    int                 request_count;
    // Percentage of cycles in which the sender holds back before a request.
    int                 sender_idle_pct;

    // The limit covers every request at the largest count with a wide margin,
    // though most requests use small counts.
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

    cubic_bezier_closest_parameter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .query_x       (query_x),
        .query_y       (query_y),
        .query_z       (query_z),
        .sample_count  (sample_count),
        .done          (done),
        .nearest_param (nearest_param)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Results cannot be held off, so every cycle with done high is checked.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(nearest_param);
    end

    // Watchdog: a hung block or a lost result ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Writes one control point. It is only called while the block is idle.
    task automatic write_point(logic [cbcp_pkg::CFG_IDX_W-1:0] idx,
                               logic [cbcp_pkg::CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        board.write_point(idx, value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [cbcp_pkg::CFG_WIDTH-1:0] pack_point(logic [20:0] x,
                                                                  logic [20:0] y,
                                                                  logic [20:0] z);
        return {z, y, x};
    endfunction

    // Sends one request: waits a random idle gap, raises start and holds it
    // until the block takes it at an edge where busy is low.
    task automatic send_request(logic [20:0] qx, logic [20:0] qy, logic [20:0] qz,
                                logic [10:0] count);
        while ($urandom_range(99, 0) < sender_idle_pct)
            @(posedge clk);
        start        <= 1'b1;
        query_x      <= qx;
        query_y      <= qy;
        query_z      <= qz;
        sample_count <= count;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(qx, qy, qz, count);
        request_count++;
        start        <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every expected result has come back, then waits on so that
    // the block is surely back in its idle state.
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Mostly small counts keep the run short; a few requests use large ones,
    // and out-of-range counts exercise the saturation.
    function automatic logic [10:0] random_count();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 80)
            return 11'($urandom_range(40, 0));
        else if (pick < 94)
            return 11'($urandom_range(200, 41));
        else if (pick < 97)
            return 11'($urandom_range(1024, 900));
        else
            return 11'($urandom_range(2047, 1025));
    endfunction

    // Query coordinates: within 4000 of zero half of the time, full range otherwise.
    function automatic logic [20:0] random_coord();
        if ($urandom_range(1, 0))
            return 21'($urandom);
        else
            return 21'($signed($urandom_range(8000, 0)) - 4000);
    endfunction

    function automatic logic [cbcp_pkg::CFG_WIDTH-1:0] random_point();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(3, 0) == 0)
            return raw[cbcp_pkg::CFG_WIDTH-1:0];
        return pack_point(random_coord(), random_coord(), random_coord());
    endfunction

    initial
    begin
        logic [20:0] max_c;
        logic [20:0] min_c;
        max_c = 21'h0F_FFFF;
        min_c = 21'h10_0000;
        board        = new();
        cycle_count  = 0;
        request_count = 0;
        sender_idle_pct = 21;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        start        = 1'b0;
        query_x      = '0;
        query_y      = '0;
        query_z      = '0;
        sample_count = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With all control points at their reset value of zero,
        // every sample ties, so the earliest sample (t = 0) must win.
        send_request(21'd5, 21'd5, 21'd5, 11'd4);
        drain();

        // A straight line from the most negative corner to the most positive
        // corner: the extremes of the coordinate range flow through every level.
        write_point(cbcp_pkg::REG_START_POINT, pack_point(min_c, min_c, min_c));
        write_point(cbcp_pkg::REG_FIRST_HANDLE, pack_point(min_c, min_c, min_c));
        write_point(cbcp_pkg::REG_SECOND_HANDLE, pack_point(max_c, max_c, max_c));
        write_point(cbcp_pkg::REG_END_POINT, pack_point(max_c, max_c, max_c));
        // A zero count is treated as one interval: only both ends are sampled.
        send_request(max_c, max_c, max_c, 11'd0);
        send_request(min_c, min_c, min_c, 11'd0);
        send_request(21'd0, 21'd0, 21'd0, 11'd1);
        send_request(max_c, min_c, max_c, 11'd3);
        send_request(21'h1F_FFFF, 21'd1, 21'd0, 11'd7);
        // The largest legal count, and counts above it that saturate.
        send_request(21'd0, 21'd0, 21'd0, 11'd1024);
        send_request(21'd300, 21'd300, 21'd300, 11'd1025);
        send_request(max_c, max_c, min_c, 11'h7FF);
        drain();

        // A curved arc with the register bits above bit 62 of the stimulus
        // irrelevant by construction; the curve loops back so ties appear.
        write_point(cbcp_pkg::REG_START_POINT, pack_point(21'd0, 21'd0, 21'd0));
        write_point(cbcp_pkg::REG_FIRST_HANDLE, pack_point(21'd2560, 21'd5120, -21'sd2560));
        write_point(cbcp_pkg::REG_SECOND_HANDLE, pack_point(21'd5120, -21'sd5120, 21'd2560));
        write_point(cbcp_pkg::REG_END_POINT, pack_point(21'd0, 21'd0, 21'd0));
        send_request(21'd0, 21'd0, 21'd0, 11'd16);
        send_request(21'd1000, 21'd500, 21'd0, 11'd5);
        send_request(21'd2000, -21'sd300, 21'd100, 11'd33);
        send_request(min_c, max_c, 21'd0, 11'd2);
        drain();

        // Random part in three phases of idling; the control points change
        // between batches while the block is idle.
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 65 : 0;
            for (int batch = 0; batch < 6; batch++)
            begin
                for (int r = 0; r < 4; r++)
                    write_point(r[cbcp_pkg::CFG_IDX_W-1:0], random_point());
                for (int k = 0; k < 7; k++)
                    send_request(random_coord(), random_coord(), random_coord(),
                                 random_count());
                drain();
            end
        end

        drain();
        $display("Ran %0d requests, %0d results checked, over extreme, curved and random",
                 request_count, board.checked);
        $display("control points with counts from zero through saturation.");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
